// File: hdl/mfs_pkg.sv
// shared types and constants of the measurement frame serializer
// no dependencies; imported by every module of the block
package mfs_pkg;

  localparam int unsigned NumValues = 6;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned GroupsPerValue = 5;
  localparam int unsigned GroupWidth = 7;
  localparam int unsigned DataLen = NumValues * GroupsPerValue;
  localparam int unsigned FrameLen = DataLen + 1;
  localparam int unsigned InDataWidth = NumValues * ValueWidth;

  localparam logic [7:0] ChkInit = 8'h46;
  localparam logic [7:0] MarkBit = 8'h80;
  localparam logic [7:0] GroupMask = 8'h7F;

  // controls of one chain cell
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // controls of the checksum unit
  typedef struct packed {
    logic upd;
    logic upd_last;
    logic take;
  } chk_ctrl_t;

endpackage

// File: hdl/mfs_cell.sv
// one byte cell of the frame chain: loads in parallel, then shifts toward the head
// depends on mfs_pkg
module mfs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfs_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]         load_byte_i,
  input  logic               next_valid_i,
  input  logic [7:0]         next_byte_i,
  output logic               valid_o,
  output logic [7:0]         byte_o
);
  import mfs_pkg::*;

  logic       valid_d, valid_q;
  logic [7:0] byte_d, byte_q;

  // next contents: parallel load or take the neighbor's byte
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (ctrl_i.load) begin
      valid_d = 1'b1;
      byte_d  = load_byte_i;
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      byte_d  = next_byte_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload byte
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// File: hdl/mfs_check.sv
// running checksum of the bytes leaving the chain, and the pending checksum byte
// depends on mfs_pkg
module mfs_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfs_pkg::chk_ctrl_t ctrl_i,
  input  logic [7:0]         byte_i,
  output logic               pending_o,
  output logic [7:0]         chk_byte_o
);
  import mfs_pkg::*;

  logic [7:0] chk_d, chk_q;
  logic       pending_d, pending_q;

  // update per data byte, back to the seed once the checksum byte is taken
  always_comb begin
    chk_d     = chk_q;
    pending_d = pending_q;
    if (ctrl_i.upd) begin
      chk_d = chk_q ^ {chk_q[6:0], 1'b1} ^ byte_i;
      if (ctrl_i.upd_last) begin
        pending_d = 1'b1;
      end
    end else if (ctrl_i.take) begin
      chk_d     = ChkInit;
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q     <= ChkInit;
      pending_q <= 1'b0;
    end else begin
      chk_q     <= chk_d;
      pending_q <= pending_d;
    end
  end

  assign pending_o  = pending_q;
  assign chk_byte_o = chk_q | MarkBit;

endmodule

// File: hdl/measurement_frame_serializer.sv
// top level of the measurement frame serializer: byte cell chain, checksum, output register
// depends on mfs_pkg, mfs_cell and mfs_check
//
// One request on the slave side carries six signed 32-bit values and yields a 31-byte
// frame on the master side: 30 data bytes (five 7-bit groups per value, least
// significant first, bit 7 set on all but the first byte) and a checksum byte with
// tlast high. The values are cut into bytes combinationally and loaded into a chain of 30
// byte cells that shifts one byte per cycle into the output register when the master
// side does not stall, while the checksum is accumulated from the bytes as they leave.
// The next request is taken in the cycle that the checksum byte enters the output
// register, so frames follow each other without gaps at one byte per clock when the
// master side never stalls. The first byte of a frame passes through its byte cell
// and the output register before it is offered on the master side.
module measurement_frame_serializer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // fields from bit 0 up: fwd_re, fwd_im, refl_re, refl_im, thru_re, thru_im
  input  logic [mfs_pkg::InDataWidth-1:0] s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // fields from bit 0 up: out_byte
  output logic [7:0]                      m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);
  import mfs_pkg::*;

  logic [DataLen-1:0] cell_valid;
  logic [7:0]         cell_byte [DataLen];
  logic [7:0]         load_byte [DataLen];
  cell_ctrl_t         cell_ctrl;
  chk_ctrl_t          chk_ctrl;
  logic               chk_pending;
  logic [7:0]         chk_byte;

  logic               out_valid_d, out_valid_q;
  logic [7:0]         out_byte_d, out_byte_q;
  logic               out_last_d, out_last_q;
  logic               out_adv;
  logic               s_accept;

  // control of chain, checksum and output register
  assign out_adv          = !out_valid_q || m_axis_tready_i;
  assign cell_ctrl.shift  = out_adv && cell_valid[0];
  assign chk_ctrl.upd     = cell_ctrl.shift;
  assign chk_ctrl.upd_last = cell_ctrl.shift && !cell_valid[1];
  assign chk_ctrl.take    = out_adv && !cell_valid[0] && chk_pending;
  assign s_axis_tready_o  = !cell_valid[0] && (!chk_pending || out_adv);
  assign s_accept         = s_axis_tvalid_i && s_axis_tready_o;
  assign cell_ctrl.load   = s_accept;

  // byte image of the request: sign-extended 7-bit groups
  for (genvar i = 0; i < DataLen; i++) begin : g_load
    localparam int unsigned Val = i / GroupsPerValue;
    localparam int unsigned Sh  = (i % GroupsPerValue) * GroupWidth;
    logic signed [ValueWidth-1:0] value;
    logic [ValueWidth-1:0]        shifted;
    assign value   = s_axis_tdata_i[Val*ValueWidth +: ValueWidth];
    assign shifted = value >>> Sh;
    assign load_byte[i] = (shifted[7:0] & GroupMask) | ((i == 0) ? 8'h00 : MarkBit);
  end

  // chain of byte cells, head at index zero
  for (genvar k = 0; k < DataLen; k++) begin : g_cell
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    if (k == DataLen - 1) begin : g_tail
      assign nxt_valid = 1'b0;
      assign nxt_byte  = 8'h00;
    end else begin : g_mid
      assign nxt_valid = cell_valid[k+1];
      assign nxt_byte  = cell_byte[k+1];
    end
    mfs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .load_byte_i  (load_byte[k]),
      .next_valid_i (nxt_valid),
      .next_byte_i  (nxt_byte),
      .valid_o      (cell_valid[k]),
      .byte_o       (cell_byte[k])
    );
  end

  // checksum accumulator
  mfs_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (chk_ctrl),
    .byte_i     (cell_byte[0]),
    .pending_o  (chk_pending),
    .chk_byte_o (chk_byte)
  );

  // output register next value
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_adv) begin
      if (cell_valid[0]) begin
        out_valid_d = 1'b1;
        out_byte_d  = cell_byte[0];
        out_last_d  = 1'b0;
      end else if (chk_pending) begin
        out_valid_d = 1'b1;
        out_byte_d  = chk_byte;
        out_last_d  = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // occupied cells always form a run from the head
  a_chain_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((cell_valid >> 1) & ~cell_valid) == '0))
    else $error("gap in the byte cell chain");

  // a request only loads an empty chain
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |-> (cell_valid == '0))
    else $error("request accepted while frame bytes remain");

  // the checksum waits only once all data bytes have left
  a_pending_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_pending |-> (cell_valid == '0))
    else $error("checksum pending with data still in the chain");

  // a shown checksum byte leaves nothing pending
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> !chk_pending)
    else $error("checksum pending behind a frame end");

  // after the final data byte the checksum follows
  a_chk_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_ctrl.upd_last |=> chk_pending)
    else $error("checksum not raised after last data byte");
`endif

endmodule
